// File: sv/lws_pkg.sv
// Package with shared types, constants and helper functions for the lexer.
package lws_pkg;

	localparam int TableDepth = 128;
	localparam int MaxLexLen = 16;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int PosW = $clog2(MaxLexLen);
	localparam int LenW = $clog2(MaxLexLen + 1);
	localparam int StoreDepth = TableDepth * MaxLexLen;
	localparam int StoreAw = $clog2(StoreDepth);
	localparam int QueueDepth = 4;
	localparam int QPtrW = $clog2(QueueDepth);

	// Token classes.
	localparam logic [2:0] ClsKeyword = 3'd0;
	localparam logic [2:0] ClsOperator = 3'd1;
	localparam logic [2:0] ClsDelim = 3'd2;
	localparam logic [2:0] ClsIdent = 3'd3;
	localparam logic [2:0] ClsInteger = 3'd4;
	localparam logic [2:0] ClsFull = 3'd5;

	// Front-to-back job kinds.
	localparam logic [1:0] JobDirect = 2'd0;
	localparam logic [1:0] JobWord = 2'd1;
	localparam logic [1:0] JobNumber = 2'd2;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [2:0] token_class;
		logic [6:0] token_index;
		logic       truncated;
		logic       last_of_run;
	} out_item_t;

	// One queued job: either a finished token or a lexeme to intern.
	typedef struct packed {
		logic [1:0]                  kind;
		logic [2:0]                  cls;
		logic [6:0]                  idx;
		logic                        trunc;
		logic                        last;
		logic [LenW-1:0]             len;
		logic [MaxLexLen-1:0][7:0]   text;
	} job_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

endpackage

// File: sv/lexer_with_symbol_tables_core.sv
// Top level of the streaming lexer with identifier and integer tables.
//
// Input channel in_valid/in_ready carries one source byte (or an end of text
// mark) per transfer; output channel out_valid/out_ready carries tokens.
// Each input transfer gives zero, one or two tokens; last_of_run marks the
// final token of a transfer.
// The front end accepts one byte per cycle while the job queue has room and
// builds lexemes; a transfer that gives two tokens holds off the next input
// until its second token is queued. Keywords, operators and delimiters pass
// straight through the back end without a search, and the back end takes no
// new job while a result waits. The back end searches a table for each
// finished word or digit run, entry by entry, comparing the length and then
// the characters in turn, then writes a new entry character by character.
// Reset empties both tables and the queue; table contents need no clearing.
// When the receiver stalls, the result register holds, the back end waits,
// the queue fills and then in_ready falls.
module lexer_with_symbol_tables_core import lws_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	logic f_valid, f_ready, b_valid, b_ready;
	job_t f_job, b_job;

	lws_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

	lws_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data(f_job), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job));

	lws_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(b_valid), .job_ready(b_ready),
		.job(b_job), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data));
endmodule

// File: sv/lws_ram.sv
// Generic single-port RAM with registered read data.
module lws_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Read before write port, read data registered.
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// File: sv/lws_front.sv
// Front end: character classification, lexeme assembly and keyword match.
module lws_front import lws_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     job_valid,
	input  logic     job_ready,
	output job_t     job
);
	typedef enum logic [1:0] {
		M_IDLE, M_WORD, M_NUMBER, M_STOPPED
	} mode_t;

	mode_t                     mode_q;
	logic [MaxLexLen-1:0][7:0] buf_q;
	logic [LenW-1:0]           len_q;
	logic                      ovf_q;
	// Second job of an item waits here.
	logic                      pend_q;
	job_t                      pend_job_q;

	logic [7:0] c;
	logic       eot, al, dg, flush, has_lex, kw_hit;
	logic [6:0] kw_idx;
	logic       tok, is_op, is_dl, is_hash;
	logic [6:0] tok_idx;
	job_t       lex_job, tok_job, first_job;
	logic       first_v, second_v;

	assign c = in_data.char_code;
	assign eot = in_data.end_of_text;
	assign al = is_alpha(c);
	assign dg = is_digit(c);
	assign has_lex = (mode_q == M_WORD) || (mode_q == M_NUMBER);

	// Keyword compare against the assembled buffer.
	always_comb begin
		kw_hit = 1'b0;
		kw_idx = 7'd0;
		if (!ovf_q && mode_q == M_WORD) begin
			if (len_q == LenW'(3) && buf_q[0] == "i" && buf_q[1] == "n" && buf_q[2] == "t") begin
				kw_hit = 1'b1; kw_idx = 7'd0;
			end
			if (MaxLexLen >= 4 && len_q == LenW'(4) && buf_q[0] == "m"
			    && buf_q[1] == "a" && buf_q[2] == "i" && buf_q[3] == "n") begin
				kw_hit = 1'b1; kw_idx = 7'd1;
			end
			if (MaxLexLen >= 6 && len_q == LenW'(6) && buf_q[0] == "r"
			    && buf_q[1] == "e" && buf_q[2] == "t" && buf_q[3] == "u"
			    && buf_q[4] == "r" && buf_q[5] == "n") begin
				kw_hit = 1'b1; kw_idx = 7'd2;
			end
		end
	end

	// Single character tokens.
	always_comb begin
		is_op = 1'b0; is_dl = 1'b0; tok_idx = 7'd0;
		case (c)
			"+": begin is_op = 1'b1; tok_idx = 7'd0; end
			"*": begin is_op = 1'b1; tok_idx = 7'd1; end
			"=": begin is_op = 1'b1; tok_idx = 7'd2; end
			"(": begin is_dl = 1'b1; tok_idx = 7'd0; end
			")": begin is_dl = 1'b1; tok_idx = 7'd1; end
			"{": begin is_dl = 1'b1; tok_idx = 7'd2; end
			"}": begin is_dl = 1'b1; tok_idx = 7'd3; end
			",": begin is_dl = 1'b1; tok_idx = 7'd4; end
			";": begin is_dl = 1'b1; tok_idx = 7'd5; end
			default: ;
		endcase
		is_hash = (c == "#");
	end

	// Decide what this item does.
	always_comb begin
		flush = 1'b0;
		tok = 1'b0;
		if (eot) flush = has_lex;
		else if (mode_q == M_STOPPED) flush = 1'b0;
		else if (mode_q == M_WORD && (al || dg)) flush = 1'b0;
		else if (mode_q == M_NUMBER && dg) flush = 1'b0;
		else begin
			flush = has_lex;
			tok = !al && !dg && (is_op || is_dl);
		end
		lex_job = '0;
		lex_job.text = buf_q;
		lex_job.len = len_q;
		lex_job.trunc = ovf_q;
		lex_job.last = !tok;
		if (kw_hit) begin
			lex_job.kind = JobDirect;
			lex_job.cls = ClsKeyword;
			lex_job.idx = kw_idx;
			lex_job.trunc = 1'b0;
		end else begin
			lex_job.kind = (mode_q == M_WORD) ? JobWord : JobNumber;
		end
		tok_job = '0;
		tok_job.kind = JobDirect;
		tok_job.cls = is_op ? ClsOperator : ClsDelim;
		tok_job.idx = tok_idx;
		tok_job.last = 1'b1;
		first_v = flush || tok;
		second_v = flush && tok;
		first_job = flush ? lex_job : tok_job;
	end

	assign in_ready = !pend_q && (job_ready || !first_v);
	assign job_valid = pend_q || (in_valid && first_v);
	assign job = pend_q ? pend_job_q : first_job;

	// Scanner state and the held second job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			len_q <= '0;
			ovf_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (pend_q && job_ready) pend_q <= 1'b0;
			if (in_valid && in_ready) begin
				if (second_v) begin
					pend_q <= 1'b1;
					pend_job_q <= tok_job;
				end
				if (eot) begin
					mode_q <= M_IDLE; len_q <= '0; ovf_q <= 1'b0;
				end else if (mode_q == M_STOPPED) begin
					mode_q <= M_STOPPED;
				end else if ((mode_q == M_WORD && (al || dg)) || (mode_q == M_NUMBER && dg)) begin
					if (len_q < LenW'(MaxLexLen)) begin
						buf_q[len_q[PosW-1:0]] <= c;
						len_q <= len_q + LenW'(1);
					end else ovf_q <= 1'b1;
				end else begin
					ovf_q <= 1'b0;
					if (al || dg) begin
						mode_q <= al ? M_WORD : M_NUMBER;
						buf_q[0] <= c;
						len_q <= LenW'(1);
					end else begin
						len_q <= '0;
						mode_q <= is_hash ? M_STOPPED : M_IDLE;
					end
				end
			end
		end
	end

	// The pending slot is only filled when an item gave two jobs.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_q) |-> $past(in_valid && in_ready))
		else $error("pending job without an accepted item");
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !in_ready)
		else $error("front accepts while a job is pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LenW'(MaxLexLen))
		else $error("lexeme length out of range");
endmodule

// File: sv/lws_queue.sv
// Short job queue between the front end and the back end.
module lws_queue import lws_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_data
);
	job_t            slot_q [QueueDepth];
	logic [QPtrW-1:0] wp_q, rp_q;
	logic [QPtrW:0]   cnt_q;
	logic             wr, rd;

	assign wr_ready = cnt_q != (QPtrW+1)'(QueueDepth);
	assign rd_valid = cnt_q != '0;
	assign rd_data = slot_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	// Ring of job slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) begin
				slot_q[wp_q] <= wr_data;
				wp_q <= wp_q + QPtrW'(1);
			end
			if (rd) rp_q <= rp_q + QPtrW'(1);
			cnt_q <= cnt_q + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPtrW+1)'(QueueDepth))
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> cnt_q == $past(cnt_q) + (QPtrW+1)'(1))
		else $error("queue count did not grow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rd && !wr) |=> cnt_q == $past(cnt_q) - (QPtrW+1)'(1))
		else $error("queue count did not shrink");
endmodule

// File: sv/lws_back.sv
// Back end: symbol table search, insertion and result register.
module lws_back import lws_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	output logic      job_ready,
	input  job_t      job,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	typedef enum logic [2:0] {
		S_IDLE, S_LEN, S_CHAR, S_WRITE, S_OUT
	} state_t;

	state_t              state_q;
	job_t                job_q;
	logic                num_q;
	logic [CntW-1:0]     name_cnt_q, num_cnt_q;
	logic [CntW-1:0]     ent_q;
	logic [PosW-1:0]     pos_q;
	logic                out_v_q;
	out_item_t           out_q;

	// Memory ports.
	logic                len_we_n, len_we_i;
	logic [LenW-1:0]     len_rd_n, len_rd_i;
	logic                ch_we_n, ch_we_i;
	logic [7:0]          ch_rd_n, ch_rd_i, ch_wd;
	logic [StoreAw-1:0]  ch_addr;
	logic [IdxW-1:0]     len_addr;
	logic [LenW-1:0]     len_rd;
	logic [7:0]          ch_rd;
	logic [CntW-1:0]     cnt;
	logic                sweep;
	logic [PosW-1:0]     cmp_pos;

	assign cnt = num_q ? num_cnt_q : name_cnt_q;
	assign len_rd = num_q ? len_rd_i : len_rd_n;
	assign ch_rd = num_q ? ch_rd_i : ch_rd_n;
	assign len_addr = ent_q[IdxW-1:0];
	assign ch_addr = {ent_q[IdxW-1:0], pos_q};
	assign cmp_pos = pos_q - PosW'(1);
	assign ch_wd = job_q.text[pos_q];
	assign sweep = (state_q == S_WRITE);
	assign len_we_n = sweep && !num_q && pos_q == '0;
	assign len_we_i = sweep && num_q && pos_q == '0;
	assign ch_we_n = sweep && !num_q;
	assign ch_we_i = sweep && num_q;

	lws_ram #(.Width(LenW), .Depth(TableDepth)) u_name_len (
		.clk(clk), .we(len_we_n), .addr(len_addr), .wdata(job_q.len), .rdata(len_rd_n));
	lws_ram #(.Width(LenW), .Depth(TableDepth)) u_num_len (
		.clk(clk), .we(len_we_i), .addr(len_addr), .wdata(job_q.len), .rdata(len_rd_i));
	lws_ram #(.Width(8), .Depth(StoreDepth)) u_name_store (
		.clk(clk), .we(ch_we_n), .addr(ch_addr), .wdata(ch_wd), .rdata(ch_rd_n));
	lws_ram #(.Width(8), .Depth(StoreDepth)) u_num_store (
		.clk(clk), .we(ch_we_i), .addr(ch_addr), .wdata(ch_wd), .rdata(ch_rd_i));

	assign job_ready = (state_q == S_IDLE) && !out_v_q;
	assign out_valid = out_v_q;
	assign out_data = out_q;

	// Search engine: per entry, S_LEN addresses the length and first character,
	// then S_CHAR compares the characters in turn; S_WRITE stores new entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			name_cnt_q <= '0;
			num_cnt_q <= '0;
			out_v_q <= 1'b0;
			ent_q <= '0;
			pos_q <= '0;
		end else begin
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (job_valid && job_ready) begin
						job_q <= job;
						num_q <= (job.kind == JobNumber);
						ent_q <= '0;
						pos_q <= '0;
						if (job.kind == JobDirect) begin
							out_q <= '{token_class: job.cls, token_index: job.idx,
								truncated: job.trunc, last_of_run: job.last};
							out_v_q <= 1'b1;
						end else state_q <= S_LEN;
					end
				end
				S_LEN: begin
					// Entry ent_q is addressed now; its data arrives next cycle.
					if (ent_q >= cnt) begin
						if (cnt >= CntW'(TableDepth)) begin
							out_q <= '{token_class: ClsFull, token_index: num_q ? 7'd1 : 7'd0,
								truncated: job_q.trunc, last_of_run: job_q.last};
							state_q <= S_OUT;
						end else begin
							pos_q <= '0;
							state_q <= S_WRITE;
						end
					end else begin
						pos_q <= PosW'(1);
						state_q <= S_CHAR;
					end
				end
				S_CHAR: begin
					// Read data holds the entry length and its character pos_q - 1.
					if (len_rd != job_q.len || ch_rd != job_q.text[cmp_pos]) begin
						ent_q <= ent_q + CntW'(1);
						pos_q <= '0;
						state_q <= S_LEN;
					end else if (LenW'(cmp_pos) + LenW'(1) == job_q.len) begin
						out_q <= '{token_class: num_q ? ClsInteger : ClsIdent,
							token_index: ent_q[IdxW-1:0], truncated: job_q.trunc,
							last_of_run: job_q.last};
						state_q <= S_OUT;
					end else pos_q <= pos_q + PosW'(1);
				end
				S_WRITE: begin
					if (LenW'(pos_q) + LenW'(1) >= job_q.len || pos_q == PosW'(MaxLexLen - 1)) begin
						if (num_q) num_cnt_q <= num_cnt_q + CntW'(1);
						else name_cnt_q <= name_cnt_q + CntW'(1);
						out_q <= '{token_class: num_q ? ClsInteger : ClsIdent,
							token_index: ent_q[IdxW-1:0], truncated: job_q.trunc,
							last_of_run: job_q.last};
						state_q <= S_OUT;
					end else pos_q <= pos_q + PosW'(1);
				end
				S_OUT: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		name_cnt_q <= CntW'(TableDepth))
		else $error("identifier count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		num_cnt_q <= CntW'(TableDepth))
		else $error("integer count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ready) |=> out_v_q && $stable(out_q))
		else $error("stalled result changed");
endmodule
